// ===== rtl/srsw_pkg.sv =====
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared types, codes and helpers for the selective-repeat sender window.
// ----------------------------------------------------------------------------
package srsw_pkg;

  localparam int WINDOW_MAX = 32;
  localparam int SEQ_WIDTH  = 32;
  localparam int BITMAP_W   = 32;
  localparam int BIT_IDX_W  = $clog2(BITMAP_W);
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef logic [SEQ_WIDTH-1:0] seq_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  // request codes
  localparam logic [1:0] FUNC_SEND    = 2'd0;
  localparam logic [1:0] FUNC_ACK     = 2'd1;
  localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

  // result codes
  localparam logic [1:0] KIND_SEND_NEW = 2'd0;
  localparam logic [1:0] KIND_RETX     = 2'd1;
  localparam logic [1:0] KIND_NO_SEND  = 2'd2;
  localparam logic [1:0] KIND_GAVE_UP  = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRIES = 2'd1;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] ack_seq;
    logic [31:0] ack_bitmap;
    logic        final_segment;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] seq_out;
    logic        transfer_done;
    logic        last_in_run;
  } out_t;

  // scan unit control and status
  typedef struct packed {
    logic load;
    logic step;
  } scan_ctl_t;

  typedef struct packed {
    logic more;
    logic unacked;
    seq_t seq;
  } scan_sts_t;

  function automatic logic [5:0] eff_window(input logic [5:0] ws);
    logic [5:0] r;
    if (ws == 6'd0) begin
      r = 6'd1;
    end else if (ws > 6'(WINDOW_MAX)) begin
      r = 6'(WINDOW_MAX);
    end else begin
      r = ws;
    end
    return r;
  endfunction

  function automatic logic done_fn(input logic ended, input seq_t nxt, input seq_t base,
                                   input seq_t ack_base, input logic [BITMAP_W-1:0] bm);
    return ended && (nxt == base) && (ack_base == nxt) && (bm == '0);
  endfunction

endpackage

// ===== rtl/srsw_scan.sv =====
// ----------------------------------------------------------------------------
// srsw_scan
// Window walker: steps one sequence number per cycle while ctl.step is set and checks it against
// the stored selective-ack bitmap.
// ----------------------------------------------------------------------------
module srsw_scan import srsw_pkg::*; (
  input  logic                clk,
  input  scan_ctl_t           ctl,
  input  seq_t                base,
  input  seq_t                ack_base,
  input  logic [BITMAP_W-1:0] ack_bitmap,
  input  cnt_t                scan_len,
  output scan_sts_t           sts
);

  seq_t seq;
  seq_t offs;
  cnt_t remaining;

  // offs tracks seq - ack_base - 1; base + ~ack_base gives that at load
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      seq       <= base;
      offs      <= base + ~ack_base;
      remaining <= scan_len;
    end else if (ctl.step) begin
      seq       <= seq + seq_t'(1);
      offs      <= offs + seq_t'(1);
      remaining <= remaining - cnt_t'(1);
    end
  end

  // seq equal to ack base lands on all ones, so it counts as out of range
  assign sts.more    = (remaining != '0);
  assign sts.unacked = (offs[SEQ_WIDTH-1:BIT_IDX_W] != '0) ||
                       !ack_bitmap[offs[BIT_IDX_W-1:0]];
  assign sts.seq     = seq;

endmodule

// ===== rtl/selective_repeat_sender_window_core.sv =====
// ----------------------------------------------------------------------------
// selective_repeat_sender_window_core
// Sender-side window bookkeeping for selective-repeat ARQ.
// ----------------------------------------------------------------------------
// Send requests, acks and other requests each put a result beat into the
// output register in the cycle after accept. A timeout walks the first
// min(outstanding, 32) window numbers one sequence number per cycle through
// the scan unit, pausing while the output side stalls, and holds in_ready
// low until the walk ends; unreceived numbers come out as a run of retransmit
// beats with last_in_run on the final one. A new item is taken while the
// previous result beat is being taken in the same cycle. Configuration
// writes are accepted every cycle.
module selective_repeat_sender_window_core import srsw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t              state, state_next;
  logic [5:0]          window_size;
  logic [7:0]          retry_limit;
  seq_t                base_seq, base_seq_next;
  seq_t                next_seq, next_seq_next;
  logic                source_ended, source_ended_next;
  logic [7:0]          timeout_count, timeout_count_next;
  seq_t                ack_base, ack_base_next;
  logic [BITMAP_W-1:0] ack_bitmap, ack_bitmap_next;
  logic                gave_up, gave_up_next;
  logic                pend_valid, pend_valid_next;
  seq_t                pend_seq, pend_seq_next;
  logic                out_valid_next;
  out_t                out_data_next;

  scan_ctl_t scan_ctl;
  scan_sts_t scan_sts;
  cnt_t      scan_len;

  logic       slot_free;
  logic       accept;
  seq_t       outstanding;
  seq_t       aseq;
  logic [7:0] tc_inc;
  logic       emit;
  logic [1:0] emit_kind;
  seq_t       emit_seq;
  logic       emit_last;

  assign cfg_ready   = 1'b1;
  assign slot_free   = !out_valid || out_ready;
  assign in_ready    = (state == ST_IDLE) && slot_free;
  assign accept      = in_valid && in_ready;
  assign outstanding = next_seq - base_seq;
  assign aseq        = in_data.ack_seq[SEQ_WIDTH-1:0];
  assign tc_inc      = (timeout_count == 8'hFF) ? timeout_count : timeout_count + 8'd1;
  assign scan_len    = (outstanding > seq_t'(WINDOW_MAX)) ? cnt_t'(WINDOW_MAX) :
                       outstanding[CNT_W-1:0];

  srsw_scan u_scan (
    .clk        (clk),
    .ctl        (scan_ctl),
    .base       (base_seq),
    .ack_base   (ack_base),
    .ack_bitmap (ack_bitmap),
    .scan_len   (scan_len),
    .sts        (scan_sts)
  );

  always_comb begin
    state_next         = state;
    base_seq_next      = base_seq;
    next_seq_next      = next_seq;
    source_ended_next  = source_ended;
    timeout_count_next = timeout_count;
    ack_base_next      = ack_base;
    ack_bitmap_next    = ack_bitmap;
    gave_up_next       = gave_up;
    pend_valid_next    = pend_valid;
    pend_seq_next      = pend_seq;
    scan_ctl           = '0;
    emit               = 1'b0;
    emit_kind          = KIND_NO_SEND;
    emit_seq           = '0;
    emit_last          = 1'b1;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          emit = 1'b1;
          if (gave_up) begin
            emit_kind = KIND_GAVE_UP;
          end else begin
            case (in_data.func)
              FUNC_SEND: begin
                if (!source_ended && (outstanding < seq_t'(eff_window(window_size)))) begin
                  emit_kind     = KIND_SEND_NEW;
                  emit_seq      = next_seq;
                  next_seq_next = next_seq + seq_t'(1);
                  if (in_data.final_segment) begin
                    source_ended_next = 1'b1;
                  end
                end
              end
              FUNC_ACK: begin
                ack_base_next   = aseq;
                ack_bitmap_next = in_data.ack_bitmap;
                if (base_seq != aseq) begin
                  base_seq_next      = aseq;
                  timeout_count_next = 8'd0;
                end
              end
              FUNC_TIMEOUT: begin
                timeout_count_next = tc_inc;
                if (tc_inc >= retry_limit) begin
                  gave_up_next = 1'b1;
                  emit_kind    = KIND_GAVE_UP;
                end else begin
                  emit            = 1'b0;
                  scan_ctl.load   = 1'b1;
                  pend_valid_next = 1'b0;
                  state_next      = ST_SCAN;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      ST_SCAN: begin
        // hold one found number back so the run's last beat can be marked
        if (scan_sts.more) begin
          if (scan_sts.unacked) begin
            if (pend_valid) begin
              if (slot_free) begin
                emit          = 1'b1;
                emit_kind     = KIND_RETX;
                emit_seq      = pend_seq;
                emit_last     = 1'b0;
                pend_seq_next = scan_sts.seq;
                scan_ctl.step = 1'b1;
              end
            end else begin
              pend_valid_next = 1'b1;
              pend_seq_next   = scan_sts.seq;
              scan_ctl.step   = 1'b1;
            end
          end else begin
            scan_ctl.step = 1'b1;
          end
        end else if (slot_free) begin
          emit            = 1'b1;
          emit_kind       = pend_valid ? KIND_RETX : KIND_NO_SEND;
          emit_seq        = pend_valid ? pend_seq : seq_t'(0);
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    out_valid_next = out_valid && !out_ready;
    out_data_next  = out_data;
    if (emit) begin
      out_valid_next              = 1'b1;
      out_data_next.kind          = emit_kind;
      out_data_next.seq_out       = 32'(emit_seq);
      out_data_next.last_in_run   = emit_last;
      out_data_next.transfer_done = done_fn(source_ended_next, next_seq_next, base_seq_next,
                                            ack_base_next, ack_bitmap_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      window_size   <= 6'd1;
      retry_limit   <= 8'd3;
      base_seq      <= '0;
      next_seq      <= '0;
      source_ended  <= 1'b0;
      timeout_count <= 8'd0;
      ack_base      <= '0;
      ack_bitmap    <= '0;
      gave_up       <= 1'b0;
      pend_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      base_seq      <= base_seq_next;
      next_seq      <= next_seq_next;
      source_ended  <= source_ended_next;
      timeout_count <= timeout_count_next;
      ack_base      <= ack_base_next;
      ack_bitmap    <= ack_bitmap_next;
      gave_up       <= gave_up_next;
      pend_valid    <= pend_valid_next;
      out_valid     <= out_valid_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WINDOW_SIZE: window_size <= cfg_data[5:0];
          REG_MAX_RETRIES: retry_limit <= cfg_data;
          default: begin
          end
        endcase
      end
    end
    pend_seq <= pend_seq_next;
    out_data <= out_data_next;
  end

`ifndef ASSERT_OFF
  a_gave_up_sticky: assert property (@(posedge clk) disable iff (rst)
    gave_up |=> gave_up)
    else $error("gave_up cleared after being set");

  a_ended_sticky: assert property (@(posedge clk) disable iff (rst)
    source_ended |=> source_ended)
    else $error("source_ended cleared after being set");

  a_no_pend_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid)
    else $error("pending retransmit left over outside a scan");

  a_mid_run_retx: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.last_in_run) |-> (out_data.kind == KIND_RETX))
    else $error("non-final beat of a run is not a retransmit");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the selective-repeat sender window core. Drives
// send requests, acks and timeout ticks over valid/ready, predicts every
// result beat from a behavioral copy of the window state, and compares each
// beat taken on the output channel in order.
// ----------------------------------------------------------------------------
module tb_top import srsw_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_HOLD = 80;
  localparam logic [1:0] FUNC_NOP = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predicted window state and register copies
  seq_t       win_base = '0;
  seq_t       win_next = '0;
  logic       src_done = 1'b0;
  logic [7:0] retry_cnt = '0;
  seq_t       sack_base = '0;
  logic [31:0] sack_map = '0;
  logic       given_up = 1'b0;
  logic [5:0] win_reg = 6'd1;
  logic [7:0] retry_reg = 8'd3;

  out_t due_beats[$];
  out_t want;
  int unsigned rx_hold = 0;
  int unsigned rx_stall = 0;
  bit idle_on = 1'b1;
  int errors = 0;
  longint unsigned cycles = 0;

  selective_repeat_sender_window_core i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stall bursts, plus a long hold-off on request
  always @(negedge clk) begin
    if (rx_hold != 0) begin
      out_ready = 1'b0;
      rx_hold--;
    end else if (rx_stall != 0) begin
      out_ready = 1'b0;
      rx_stall--;
    end else begin
      out_ready = 1'b1;
      if (idle_on && $urandom_range(0, 5) == 0) rx_stall = $urandom_range(1, 9);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (due_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %p", $time, out_data);
        errors++;
      end else begin
        want = due_beats.pop_front();
        if (out_data.kind !== want.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, out_data.kind);
          errors++;
        end
        if (out_data.seq_out !== want.seq_out) begin
          $display("%0t: seq_out expected %h actual %h", $time, want.seq_out,
                   out_data.seq_out);
          errors++;
        end
        if (out_data.transfer_done !== want.transfer_done) begin
          $display("%0t: transfer_done expected %b actual %b", $time,
                   want.transfer_done, out_data.transfer_done);
          errors++;
        end
        if (out_data.last_in_run !== want.last_in_run) begin
          $display("%0t: last_in_run expected %b actual %b", $time,
                   want.last_in_run, out_data.last_in_run);
          errors++;
        end
      end
    end
  end

  function automatic out_t beat(input logic [1:0] k, input seq_t s);
    out_t b;
    b = '0;
    b.kind = k;
    b.seq_out = s;
    return b;
  endfunction

  // advance the predicted window by one accepted request and queue its beats
  task automatic sender_window_next(input in_t it);
    out_t run[$];
    seq_t outstanding;
    seq_t s;
    seq_t off;
    int unsigned scan;
    logic [5:0] win;
    logic hit;
    logic done;
    outstanding = win_next - win_base;
    win = (win_reg == 6'd0) ? 6'd1 : (win_reg > 6'(WINDOW_MAX)) ? 6'(WINDOW_MAX) : win_reg;
    if (given_up) begin
      run.push_back(beat(KIND_GAVE_UP, '0));
    end else begin
      case (it.func)
        FUNC_SEND: begin
          if (!src_done && outstanding < seq_t'(win)) begin
            run.push_back(beat(KIND_SEND_NEW, win_next));
            win_next = win_next + seq_t'(1);
            if (it.final_segment) src_done = 1'b1;
          end else begin
            run.push_back(beat(KIND_NO_SEND, '0));
          end
        end
        FUNC_ACK: begin
          sack_base = it.ack_seq;
          sack_map = it.ack_bitmap;
          if (win_base != it.ack_seq) begin
            win_base = it.ack_seq;
            retry_cnt = '0;
          end
          run.push_back(beat(KIND_NO_SEND, '0));
        end
        FUNC_TIMEOUT: begin
          if (retry_cnt != 8'hFF) retry_cnt = retry_cnt + 8'd1;
          if (retry_cnt >= retry_reg) begin
            given_up = 1'b1;
            run.push_back(beat(KIND_GAVE_UP, '0));
          end else begin
            scan = (outstanding > WINDOW_MAX) ? WINDOW_MAX : outstanding;
            for (int unsigned i = 0; i < scan; i++) begin
              s = win_base + seq_t'(i);
              off = s - sack_base - seq_t'(1);
              // the stored base itself and offsets past the map are unreceived
              hit = (s != sack_base) && (off < 32) && sack_map[off[4:0]];
              if (!hit) run.push_back(beat(KIND_RETX, s));
            end
            if (run.size() == 0) run.push_back(beat(KIND_NO_SEND, '0));
          end
        end
        default: begin
          run.push_back(beat(KIND_NO_SEND, '0));
        end
      endcase
    end
    done = src_done && (win_next == win_base) && (sack_base == win_next) && (sack_map == '0);
    foreach (run[j]) begin
      run[j].transfer_done = done;
      run[j].last_in_run = (j == run.size() - 1);
      due_beats.push_back(run[j]);
    end
  endtask

  function automatic bit timeout_safe();
    logic [8:0] n;
    n = (retry_cnt == 8'hFF) ? 9'd255 : {1'b0, retry_cnt} + 9'd1;
    return !given_up && (n < {1'b0, retry_reg});
  endfunction

  task automatic push_item(input in_t it);
    int unsigned gap;
    gap = 0;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 9);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (!in_ready);
    sender_window_next(it);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (due_beats.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_WINDOW_SIZE: win_reg = val[5:0];
      REG_MAX_RETRIES: retry_reg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic in_t make_item(input logic [1:0] f, input seq_t aseq,
                                    input logic [31:0] amap, input logic fin);
    in_t it;
    it.func = f;
    it.ack_seq = aseq;
    it.ack_bitmap = amap;
    it.final_segment = fin;
    return it;
  endfunction

  // reset register values: window of one, three retries
  task automatic test_reset_window();
    push_item(make_item(FUNC_SEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    // refused request, final flag must not end the source
    push_item(make_item(FUNC_SEND, '0, '0, 1'b1));
    push_item(make_item(FUNC_ACK, 32'd1, '0, 1'b1));
    push_item(make_item(FUNC_SEND, '0, '0, 1'b0));
    push_item(make_item(FUNC_TIMEOUT, '0, '0, 1'b0));
    push_item(make_item(FUNC_TIMEOUT, '0, '0, 1'b0));
    // same base again keeps the retry count
    push_item(make_item(FUNC_ACK, 32'd1, 32'hFFFF_FFFF, 1'b0));
    push_item(make_item(FUNC_ACK, 32'd2, '0, 1'b0));
    push_item(make_item(FUNC_TIMEOUT, '0, '0, 1'b0));
  endtask

  task automatic test_config_limits_and_wrap();
    write_reg(REG_WINDOW_SIZE, 8'hC0);
    write_reg(REG_MAX_RETRIES, 8'hFF);
    write_reg(REG_SPARE_A, 8'h5A);
    write_reg(REG_SPARE_B, 8'hA5);
    push_item(make_item(FUNC_ACK, win_next, '0, 1'b0));
    push_item(make_item(FUNC_SEND, '0, '0, 1'b0));
    push_item(make_item(FUNC_SEND, '0, '0, 1'b0));
    write_reg(REG_WINDOW_SIZE, 8'hFF);
    // base just below the wrap point, run crosses zero
    push_item(make_item(FUNC_ACK, 32'hFFFF_FFF0, 32'h8000_0005, 1'b0));
    push_item(make_item(FUNC_TIMEOUT, '0, '0, 1'b0));
    push_item(make_item(FUNC_ACK, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0));
    push_item(make_item(FUNC_TIMEOUT, '0, '0, 1'b0));
    // base far ahead of next, scan is cut at the window limit
    push_item(make_item(FUNC_ACK, 32'h8000_0000, 32'h7FFF_FFFE, 1'b0));
    push_item(make_item(FUNC_TIMEOUT, '0, '0, 1'b0));
    push_item(make_item(FUNC_ACK, win_next, '0, 1'b0));
  endtask

  task automatic test_backpressure_fill();
    write_reg(REG_WINDOW_SIZE, 8'd32);
    write_reg(REG_MAX_RETRIES, 8'd255);
    idle_on = 1'b0;
    push_item(make_item(FUNC_ACK, win_next, '0, 1'b0));
    rx_hold = LONG_HOLD;
    repeat (36) push_item(make_item(FUNC_SEND, $urandom, $urandom, 1'b0));
    push_item(make_item(FUNC_ACK, win_base, 32'hA5A5_0F0F, 1'b0));
    if (timeout_safe()) push_item(make_item(FUNC_TIMEOUT, '0, '0, 1'b0));
    push_item(make_item(FUNC_ACK, win_next, '0, 1'b0));
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic(input int unsigned count);
    in_t it;
    seq_t outstanding;
    int unsigned pick;
    repeat (count) begin
      it = make_item(FUNC_SEND, $urandom, $urandom, 1'($urandom_range(0, 1)));
      outstanding = win_next - win_base;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        it.func = FUNC_SEND;
      end else if (pick < 75) begin
        // well-formed ack inside the window, or pull base back near next
        it.func = FUNC_ACK;
        if (outstanding <= WINDOW_MAX) begin
          it.ack_seq = win_base + seq_t'($urandom_range(0, outstanding));
        end else begin
          it.ack_seq = win_next - seq_t'($urandom_range(0, 4));
        end
        if ($urandom_range(0, 3) == 0) begin
          it.ack_bitmap = '0;
        end else if ($urandom_range(0, 1) == 1) begin
          it.ack_bitmap = it.ack_bitmap & ((32'h1 << $urandom_range(0, 31)) - 1);
        end
      end else if (pick < 90) begin
        it.func = FUNC_TIMEOUT;
      end else begin
        it.func = 2'($urandom_range(0, 3));
      end
      if (it.func == FUNC_SEND) it.final_segment = 1'b0;
      // keep the link alive: swap a fatal timeout for a base-moving ack
      if (it.func == FUNC_TIMEOUT && !timeout_safe()) begin
        it.func = FUNC_ACK;
        it.ack_seq = win_base + seq_t'(1);
        it.ack_bitmap = '0;
      end
      push_item(it);
    end
  endtask

  task automatic test_transfer_completion();
    push_item(make_item(FUNC_ACK, win_next, '0, 1'b0));
    push_item(make_item(FUNC_SEND, '0, '0, 1'b1));
    push_item(make_item(FUNC_ACK, win_next, 32'h0000_0001, 1'b0));
    push_item(make_item(FUNC_ACK, win_next, '0, 1'b0));
    push_item(make_item(FUNC_SEND, '0, '0, 1'b0));
    if (timeout_safe()) push_item(make_item(FUNC_TIMEOUT, '0, '0, 1'b0));
  endtask

  task automatic test_give_up();
    write_reg(REG_MAX_RETRIES, 8'd0);
    push_item(make_item(FUNC_TIMEOUT, '0, '0, 1'b0));
    push_item(make_item(FUNC_SEND, '0, '0, 1'b1));
    push_item(make_item(FUNC_ACK, $urandom, $urandom, 1'b0));
    push_item(make_item(FUNC_TIMEOUT, '0, '0, 1'b0));
    push_item(make_item(FUNC_NOP, '0, '0, 1'b0));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_window();
    test_config_limits_and_wrap();
    test_backpressure_fill();

    write_reg(REG_WINDOW_SIZE, 8'd16);
    write_reg(REG_MAX_RETRIES, 8'd255);
    test_random_traffic(45);
    write_reg(REG_WINDOW_SIZE, 8'd1);
    write_reg(REG_MAX_RETRIES, 8'd2);
    test_random_traffic(25);
    write_reg(REG_WINDOW_SIZE, 8'h47);
    write_reg(REG_MAX_RETRIES, 8'd1);
    test_random_traffic(20);
    write_reg(REG_WINDOW_SIZE, 8'd33);
    write_reg(REG_MAX_RETRIES, 8'd12);
    test_random_traffic(30);

    // closing stretch runs without any idling
    write_reg(REG_WINDOW_SIZE, 8'd5);
    write_reg(REG_MAX_RETRIES, 8'd6);
    idle_on = 1'b0;
    test_random_traffic(30);
    test_transfer_completion();
    test_give_up();

    wait_drained();
    repeat (40) @(negedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/srsw_pkg.sv
rtl/srsw_scan.sv
rtl/selective_repeat_sender_window_core.sv
tb/sv/tb_top.sv
